// File: hw/rtl/hrsp_pkg.sv
// ---------------------------------------------------------------------------
// hrsp_pkg
// Shared types, codes and character helpers for the HTTP response parser.
// ---------------------------------------------------------------------------
package hrsp_pkg;

	// Width of the length value and the body counter.
	localparam int CNT_W = 32;

	// Item kinds on the input stream.
	localparam logic [1:0] K_START = 2'd0;
	localparam logic [1:0] K_DATA  = 2'd1;
	localparam logic [1:0] K_EOF   = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_WAIT   = 3'd1,
		PH_HEAD   = 3'd2,
		PH_BODY   = 3'd3,
		PH_CLOSED = 3'd4,
		PH_BROKEN = 3'd5
	} phase_t;

	// Status line matcher: 0..6 walk the literal, then these.
	localparam logic [3:0] SL_LIT_END  = 4'd7;
	localparam logic [3:0] SL_PRE_MIN  = 4'd7;
	localparam logic [3:0] SL_SIGN     = 4'd8;
	localparam logic [3:0] SL_MINOR    = 4'd9;
	localparam logic [3:0] SL_GAP      = 4'd10;
	localparam logic [3:0] SL_CODE     = 4'd11;
	localparam logic [3:0] SL_DONE     = 4'd12;
	localparam logic [3:0] SL_FAIL     = 4'd13;

	// Header line matcher.
	localparam logic [3:0] HL_PREFIX   = 4'd0;
	localparam logic [3:0] HL_OTHER    = 4'd1;
	localparam logic [3:0] HL_LEAD     = 4'd2;
	localparam logic [3:0] HL_SIGNED   = 4'd3;
	localparam logic [3:0] HL_ZERO     = 4'd4;
	localparam logic [3:0] HL_ZEROX    = 4'd5;
	localparam logic [3:0] HL_DIGITS   = 4'd6;
	localparam logic [3:0] HL_STOP     = 4'd7;

	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic [4:0] POS_MAX    = 5'd31;
	localparam logic [4:0] PREFIX_LEN = 5'd16;

	typedef struct packed {
		phase_t             phase;
		logic               pend_cr;
		logic [4:0]         line_pos;
		logic [3:0]         line_match;
		logic [1:0]         base;
		logic [15:0]        status_val;
		logic [CNT_W-1:0]   length_val;
		logic               length_seen;
		logic [CNT_W-1:0]   body_cnt;
		logic               status_ok;
		logic [CNT_W-1:0]   acc;
		logic               neg;
		logic               sat;
	} st_t;

	typedef struct packed {
		phase_t       parse_state;
		logic [15:0]  resp_status;
		logic         status_valid;
		logic [31:0]  resp_length;
		logic         has_length;
		logic         body_valid;
		logic [7:0]   body_data;
		logic         response_done;
	} res_t;

	function automatic st_t st_reset();
		st_t s;
		s             = '0;
		s.phase       = PH_IDLE;
		s.base        = BASE_DEC;
		return s;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	// {valid, value} of a hex digit, either case.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if ((c >= "0") && (c <= "9")) begin
			t = c - 8'h30;
			return {1'b1, t[3:0]};
		end
		if ((c >= "a") && (c <= "f")) begin
			t = c - 8'h57;
			return {1'b1, t[3:0]};
		end
		if ((c >= "A") && (c <= "F")) begin
			t = c - 8'h37;
			return {1'b1, t[3:0]};
		end
		return 5'd0;
	endfunction

	function automatic logic [7:0] status_lit(input logic [3:0] i);
		case (i)
			4'd0: return "H";
			4'd1: return "T";
			4'd2: return "T";
			4'd3: return "P";
			4'd4: return "/";
			4'd5: return "1";
			4'd6: return ".";
			default: return 8'h00;
		endcase
	endfunction

	// Lower-case form of the length header prefix.
	function automatic logic [7:0] length_lit(input logic [3:0] i);
		case (i)
			4'd0:  return "c";
			4'd1:  return "o";
			4'd2:  return "n";
			4'd3:  return "t";
			4'd4:  return "e";
			4'd5:  return "n";
			4'd6:  return "t";
			4'd7:  return "-";
			4'd8:  return "l";
			4'd9:  return "e";
			4'd10: return "n";
			4'd11: return "g";
			4'd12: return "t";
			4'd13: return "h";
			4'd14: return ":";
			4'd15: return " ";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [4:0] pos_inc(input logic [4:0] p);
		return (p == POS_MAX) ? p : p + 5'd1;
	endfunction

	// Line character step for a CR that was not followed by LF.
	// CR is white space, never a digit, sign or literal character.
	function automatic st_t feed_cr(input st_t s);
		st_t n;
		n = s;
		if (s.phase == PH_WAIT) begin
			case (s.line_match)
				SL_PRE_MIN, SL_GAP, SL_DONE, SL_FAIL: n.line_match = s.line_match;
				SL_SIGN:  n.line_match = SL_FAIL;
				SL_MINOR: n.line_match = SL_GAP;
				SL_CODE:  n.line_match = SL_DONE;
				default:  n.line_match = SL_FAIL;
			endcase
		end else begin
			case (s.line_match)
				HL_PREFIX: n.line_match = HL_OTHER;
				HL_SIGNED, HL_ZERO, HL_ZEROX, HL_DIGITS: n.line_match = HL_STOP;
				default: n.line_match = s.line_match;
			endcase
		end
		n.line_pos = pos_inc(s.line_pos);
		return n;
	endfunction

endpackage

// File: hw/rtl/http_response_stream_parser_top.sv
// ---------------------------------------------------------------------------
// http_response_stream_parser_top
// HTTP/1.x response parser: status line, Content-Length, body framing.
// ---------------------------------------------------------------------------
//
// Channel  Dir  Beat carries                     Accepted when
// s_*      in   tuser: kind, tdata: data_byte    s_tvalid && s_tready
// m_*      out  tdata/tuser/tlast: one result    m_tvalid && m_tready
//
// One beat in per clock, one result beat out per input beat. Each beat passes
// through the input register, then the parse step into the result register.
// The parser state updates on the same edge that loads the result register.
// arst_n clears all control and parser state; the parser comes up idle.
// When m_tready is low the result register holds, the input register fills,
// and s_tready drops only once both are occupied.
//
module http_response_stream_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] parse_state, [18:3] resp_status, [19] status_valid,
	// [51:20] resp_length, [52] has_length, [60:53] body_data, [63:61] zero
	output logic [63:0] m_tdata,
	output logic        m_tuser,   // [0] body_valid
	output logic        m_tlast    // response_done
);

	// Input register
	logic           valid_s1;
	logic [1:0]     kind_s1;
	logic [7:0]     byte_s1;

	// Parser state and result register
	hrsp_pkg::st_t  st_q;
	hrsp_pkg::st_t  st_n;
	hrsp_pkg::res_t res;
	hrsp_pkg::res_t res_q;
	logic           out_valid_q;

	logic           advance;

	// Item in s1 moves on when the result slot is free or draining this cycle.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	hrsp_step u_step (
		.st        (st_q),
		.kind      (kind_s1),
		.data_byte (byte_s1),
		.st_n      (st_n),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= hrsp_pkg::st_reset();
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance) begin
				st_q        <= st_n;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
		if (advance)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, res_q.body_data, res_q.has_length, res_q.resp_length,
	                   res_q.status_valid, res_q.resp_status, res_q.parse_state};
	assign m_tuser  = res_q.body_valid;
	assign m_tlast  = res_q.response_done;

endmodule

// File: hw/rtl/hrsp_digit.sv
// ---------------------------------------------------------------------------
// hrsp_digit
// One digit of the saturating length accumulator (base 8, 10 or 16).
// ---------------------------------------------------------------------------
module hrsp_digit (
	input  logic [7:0]                 c,
	input  logic [1:0]                 base,
	input  logic [hrsp_pkg::CNT_W-1:0] acc,
	input  logic                       sat,
	output logic                       ok,
	output logic [hrsp_pkg::CNT_W-1:0] acc_n,
	output logic                       sat_n
);

	localparam int W = hrsp_pkg::CNT_W;

	logic [4:0]   hd;
	logic [4:0]   radix;
	logic [W+3:0] wide;
	logic [W+3:0] prod;
	logic [W+3:0] sum;

	assign hd   = hrsp_pkg::hex_digit(c);
	assign wide = {4'b0000, acc};

	always_comb begin
		case (base)
			hrsp_pkg::BASE_HEX: begin
				radix = 5'd16;
				prod  = wide << 4;
			end
			hrsp_pkg::BASE_OCT: begin
				radix = 5'd8;
				prod  = wide << 3;
			end
			default: begin
				radix = 5'd10;
				prod  = (wide << 3) + (wide << 1);
			end
		endcase
	end

	assign sum = prod + {{W{1'b0}}, hd[3:0]};
	assign ok  = hd[4] && ({1'b0, hd[3:0]} < radix);

	always_comb begin
		acc_n = acc;
		sat_n = sat;
		if (!sat) begin
			if (sum[W+3:W] != 4'd0) begin
				sat_n = 1'b1;
				acc_n = {W{1'b1}};
			end else begin
				acc_n = sum[W-1:0];
			end
		end
	end

endmodule

// File: hw/rtl/hrsp_step.sv
// ---------------------------------------------------------------------------
// hrsp_step
// Next parser state and result for one item, given the current state.
// ---------------------------------------------------------------------------
module hrsp_step (
	input  hrsp_pkg::st_t  st,
	input  logic [1:0]     kind,
	input  logic [7:0]     data_byte,
	output hrsp_pkg::st_t  st_n,
	output hrsp_pkg::res_t res
);

	localparam int W = hrsp_pkg::CNT_W;

	logic         dg_ok;
	logic [W-1:0] dg_acc;
	logic         dg_sat;

	// acc, base and sat are never touched by a CR step, so the current state feeds it.
	hrsp_digit u_digit (
		.c     (data_byte),
		.base  (st.base),
		.acc   (st.acc),
		.sat   (st.sat),
		.ok    (dg_ok),
		.acc_n (dg_acc),
		.sat_n (dg_sat)
	);

	always_comb begin
		hrsp_pkg::st_t n;
		logic          line_end;
		logic          do_feed;
		logic          done;
		logic          bvalid;
		logic [4:0]    hd;
		logic [7:0]    low;
		logic [19:0]   sv;
		logic [W-1:0]  cnt;
		logic          hd_sign;
		logic          hd_start;

		n        = st;
		line_end = 1'b0;
		do_feed  = 1'b0;
		done     = 1'b0;
		bvalid   = 1'b0;
		hd       = hrsp_pkg::hex_digit(data_byte);
		low      = ((data_byte >= "A") && (data_byte <= "Z")) ? data_byte + 8'd32 : data_byte;
		sv       = ({4'b0000, st.status_val} << 3) + ({4'b0000, st.status_val} << 1)
		           + {16'h0000, hd[3:0]};
		cnt      = (st.body_cnt == {W{1'b1}}) ? st.body_cnt : st.body_cnt + W'(1);
		hd_sign  = 1'b0;
		hd_start = 1'b0;

		case (kind)
			hrsp_pkg::K_START: begin
				n       = hrsp_pkg::st_reset();
				n.phase = hrsp_pkg::PH_WAIT;
			end
			hrsp_pkg::K_DATA: begin
				if ((st.phase == hrsp_pkg::PH_WAIT) || (st.phase == hrsp_pkg::PH_HEAD)) begin
					if (st.pend_cr) begin
						n.pend_cr = 1'b0;
						if (data_byte == hrsp_pkg::CH_LF)
							line_end = 1'b1;
						else
							n = hrsp_pkg::feed_cr(n);
					end
					if (!line_end) begin
						if (data_byte == hrsp_pkg::CH_CR)
							n.pend_cr = 1'b1;
						else
							do_feed = 1'b1;
					end

					if (do_feed) begin
						if (n.phase == hrsp_pkg::PH_WAIT) begin
							case (n.line_match)
								hrsp_pkg::SL_PRE_MIN: begin
									if (!hrsp_pkg::is_ws(data_byte)) begin
										if ((data_byte == "+") || (data_byte == "-"))
											n.line_match = hrsp_pkg::SL_SIGN;
										else if (hrsp_pkg::is_dec(data_byte))
											n.line_match = hrsp_pkg::SL_MINOR;
										else
											n.line_match = hrsp_pkg::SL_FAIL;
									end
								end
								hrsp_pkg::SL_SIGN: begin
									n.line_match = hrsp_pkg::is_dec(data_byte) ?
										hrsp_pkg::SL_MINOR : hrsp_pkg::SL_FAIL;
								end
								hrsp_pkg::SL_MINOR: begin
									if (!hrsp_pkg::is_dec(data_byte))
										n.line_match = hrsp_pkg::is_ws(data_byte) ?
											hrsp_pkg::SL_GAP : hrsp_pkg::SL_FAIL;
								end
								hrsp_pkg::SL_GAP: begin
									if (!hrsp_pkg::is_ws(data_byte)) begin
										if (hrsp_pkg::is_dec(data_byte)) begin
											n.line_match = hrsp_pkg::SL_CODE;
											n.status_val = {12'h000, hd[3:0]};
										end else begin
											n.line_match = hrsp_pkg::SL_FAIL;
										end
									end
								end
								hrsp_pkg::SL_CODE: begin
									if (!hrsp_pkg::is_dec(data_byte))
										n.line_match = hrsp_pkg::SL_DONE;
									else if (sv[19:16] != 4'd0)
										n.status_val = 16'hFFFF;
									else
										n.status_val = sv[15:0];
								end
								hrsp_pkg::SL_DONE, hrsp_pkg::SL_FAIL: begin
									n.line_match = n.line_match;
								end
								default: begin
									if ((n.line_match < hrsp_pkg::SL_LIT_END) &&
									    (data_byte == hrsp_pkg::status_lit(n.line_match)))
										n.line_match = n.line_match + 4'd1;
									else
										n.line_match = hrsp_pkg::SL_FAIL;
								end
							endcase
						end else begin
							case (n.line_match)
								hrsp_pkg::HL_PREFIX: begin
									if ((n.line_pos < hrsp_pkg::PREFIX_LEN) &&
									    (low == hrsp_pkg::length_lit(n.line_pos[3:0]))) begin
										if (n.line_pos == hrsp_pkg::PREFIX_LEN - 5'd1) begin
											n.line_match = hrsp_pkg::HL_LEAD;
											n.acc        = '0;
											n.neg        = 1'b0;
											n.sat        = 1'b0;
											n.base       = hrsp_pkg::BASE_DEC;
										end
									end else begin
										n.line_match = hrsp_pkg::HL_OTHER;
									end
								end
								hrsp_pkg::HL_LEAD: begin
									if (!hrsp_pkg::is_ws(data_byte)) begin
										if ((data_byte == "+") || (data_byte == "-")) begin
											n.neg        = (data_byte == "-");
											n.line_match = hrsp_pkg::HL_SIGNED;
										end else begin
											hd_sign = 1'b1;
										end
									end
								end
								hrsp_pkg::HL_SIGNED: hd_sign = 1'b1;
								hrsp_pkg::HL_ZERO: begin
									if ((data_byte == "x") || (data_byte == "X")) begin
										n.line_match = hrsp_pkg::HL_ZEROX;
									end else if ((data_byte >= "0") && (data_byte <= "7")) begin
										n.base   = hrsp_pkg::BASE_OCT;
										hd_start = 1'b1;
									end else begin
										n.line_match = hrsp_pkg::HL_STOP;
									end
								end
								hrsp_pkg::HL_ZEROX: begin
									if (hd[4]) begin
										n.base   = hrsp_pkg::BASE_HEX;
										hd_start = 1'b1;
									end else begin
										n.line_match = hrsp_pkg::HL_STOP;
									end
								end
								hrsp_pkg::HL_DIGITS: begin
									if (!dg_ok) begin
										n.line_match = hrsp_pkg::HL_STOP;
									end else begin
										n.acc = dg_acc;
										n.sat = dg_sat;
									end
								end
								default: n.line_match = n.line_match;
							endcase

							// after the sign, or with none
							if (hd_sign) begin
								if (data_byte == "0") begin
									n.line_match = hrsp_pkg::HL_ZERO;
								end else if (hrsp_pkg::is_dec(data_byte)) begin
									n.base   = hrsp_pkg::BASE_DEC;
									hd_start = 1'b1;
								end else begin
									n.line_match = hrsp_pkg::HL_STOP;
								end
							end
							// first digit is valid in its base and sat is clear here
							if (hd_start) begin
								n.acc        = {{(W-4){1'b0}}, hd[3:0]};
								n.line_match = hrsp_pkg::HL_DIGITS;
							end
						end
						n.line_pos = hrsp_pkg::pos_inc(n.line_pos);
					end

					if (line_end) begin
						if (n.phase == hrsp_pkg::PH_WAIT) begin
							if ((n.line_match == hrsp_pkg::SL_CODE) ||
							    (n.line_match == hrsp_pkg::SL_DONE)) begin
								n.status_ok = 1'b1;
								n.phase     = hrsp_pkg::PH_HEAD;
							end else begin
								n.phase = hrsp_pkg::PH_BROKEN;
							end
						end else if (n.line_pos == 5'd0) begin
							// empty line: body starts, or the response is done if the length is zero
							n.phase    = hrsp_pkg::PH_BODY;
							n.body_cnt = '0;
							if (n.length_seen && (n.length_val == '0)) begin
								n.phase = hrsp_pkg::PH_IDLE;
								done    = 1'b1;
							end
						end else if (n.line_match >= hrsp_pkg::HL_LEAD) begin
							if (n.line_match < hrsp_pkg::HL_DIGITS)
								n.acc = '0;
							if (n.sat)
								n.length_val = {W{1'b1}};
							else if (n.neg)
								n.length_val = '0 - n.acc;
							else
								n.length_val = n.acc;
							n.length_seen = 1'b1;
						end
						n.line_pos   = 5'd0;
						n.line_match = 4'd0;
						n.pend_cr    = 1'b0;
					end
				end else if (st.phase == hrsp_pkg::PH_BODY) begin
					bvalid     = 1'b1;
					n.body_cnt = cnt;
					if (st.length_seen && (cnt >= st.length_val)) begin
						n.phase = hrsp_pkg::PH_IDLE;
						done    = 1'b1;
					end
				end
			end
			hrsp_pkg::K_EOF: begin
				case (st.phase)
					hrsp_pkg::PH_WAIT, hrsp_pkg::PH_HEAD: n.phase = hrsp_pkg::PH_BROKEN;
					hrsp_pkg::PH_BODY: begin
						if (st.length_seen) begin
							n.phase = hrsp_pkg::PH_BROKEN;
						end else begin
							n.phase = hrsp_pkg::PH_CLOSED;
							done    = 1'b1;
						end
					end
					hrsp_pkg::PH_IDLE: n.phase = hrsp_pkg::PH_CLOSED;
					default: n.phase = st.phase;
				endcase
			end
			default: n = st;
		endcase

		st_n               = n;
		res.parse_state    = n.phase;
		res.resp_status    = n.status_ok ? n.status_val : 16'h0000;
		res.status_valid   = n.status_ok;
		res.resp_length    = 32'(n.length_val);
		res.has_length     = n.length_seen;
		res.body_valid     = bvalid;
		res.body_data      = bvalid ? data_byte : 8'h00;
		res.response_done  = done;
	end

endmodule
